// ===== design/page_frame_allocator_unit_assert.svh =====
// Assertion macros for the page frame allocator
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PFA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PFA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFA_ASSERT(label, clk, rstn, prop, msg)
`define PFA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/pfa_pkg.sv =====
// Package for the page frame allocator: constants, codes and state type
`timescale 1ns / 1ps
package pfa_pkg;
    localparam int unsigned PFA_PAGE_COUNT = 32768;
    localparam logic [14:0] START_PAGE_RST = 15'd256;
    localparam logic [15:0] KERNEL_LIMIT_RST = 16'd1024;

    localparam logic [0:0] REG_START = 1'b0;
    localparam logic [0:0] REG_LIMIT = 1'b1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_BAD = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_MARK,
        ST_FCHK,
        ST_DONE
    } pfa_state_t;
endpackage

// ===== design/page_frame_allocator_unit.sv =====
// Page frame allocator: used-page bitmap with first-fit run allocation
// After reset the block sweeps the bitmap, one page a cycle, marking every page used,
// with s_ready low. The bitmap is a one-bit-wide memory and a single page sequencer
// walks it. An allocate reads and checks each page from the configured start page up
// to the end of the fitting run, then marks the run; a no-space allocate scans to the
// last page. A free reads each page of the run and clears it if it is used. Zero-length
// and out-of-range requests go straight to the response.
// Counters saturate at 0 and 65535.
`timescale 1ns / 1ps
`include "page_frame_allocator_unit_assert.svh"
module page_frame_allocator_unit #(
    parameter int unsigned PAGE_COUNT = pfa_pkg::PFA_PAGE_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic        s_kernel_kind,
    input  logic [15:0] s_run_length,
    input  logic [14:0] s_page_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [14:0] m_first_page,
    output logic [15:0] m_free_total,
    output logic [15:0] m_free_kernel
);
    import pfa_pkg::*;

    localparam int AW = $clog2(PAGE_COUNT);
    localparam int XW = (AW + 1 > 17) ? AW + 1 : 17;
    localparam logic [XW-1:0] PC_X = XW'(PAGE_COUNT);

    pfa_state_t state_reg, state_next;
    logic [14:0] start_cfg_reg;
    logic [15:0] limit_cfg_reg;
    logic        action_reg, action_next;
    logic        kind_reg, kind_next;
    logic [XW-1:0] len_reg, len_next;
    logic [XW-1:0] p_reg, p_next;
    logic [XW-1:0] end_reg, end_next;
    logic [XW-1:0] run_reg, run_next;
    logic [XW-1:0] q_reg, q_next;
    logic [XW-1:0] first_reg, first_next;
    logic [1:0]  stat_reg, stat_next;
    logic [15:0] tot_reg, tot_next;
    logic [15:0] kern_reg, kern_next;
    logic [AW:0] clr_reg, clr_next;
    logic        mv_reg, mv_next;
    logic [1:0]  ms_reg, ms_next;
    logic [14:0] mf_reg, mf_next;
    logic [15:0] mt_reg, mt_next;
    logic [15:0] mk_reg, mk_next;

    logic          mem [PAGE_COUNT];
    logic          rd_data;
    logic          mem_we, mem_wd;
    logic [AW-1:0] mem_wa;

    logic [XW-1:0] s_len_x, s_start_x, p_inc, run_inc, start_x, limit_x;
    logic          page_is_kern;

    assign s_len_x   = XW'(s_run_length);
    assign s_start_x = XW'(s_page_number);
    assign start_x   = XW'(start_cfg_reg);
    assign limit_x   = XW'(limit_cfg_reg);
    assign p_inc     = p_reg + XW'(1);
    assign run_inc   = run_reg + XW'(1);
    assign page_is_kern = p_reg < limit_x;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[p_reg[AW-1:0]];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(PAGE_COUNT - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_len_x == '0) begin
                        state_next = ST_DONE;
                    end else if (s_action == ACT_ALLOC) begin
                        if (s_len_x > PC_X || start_x >= PC_X) state_next = ST_DONE;
                        else state_next = ST_RD;
                    end else begin
                        if (s_start_x >= PC_X || s_len_x > PC_X - s_start_x)
                            state_next = ST_DONE;
                        else state_next = ST_RD;
                    end
                end
            end
            ST_RD: state_next = (action_reg == ACT_ALLOC) ? ST_CHK : ST_FCHK;
            ST_CHK: begin
                if (!rd_data && (page_is_kern == kind_reg) && run_inc == len_reg)
                    state_next = ST_MARK;
                else if (p_inc >= PC_X) state_next = ST_DONE;
                else state_next = ST_RD;
            end
            ST_MARK: if (q_reg == p_reg) state_next = ST_DONE;
            ST_FCHK: state_next = (p_inc == end_reg) ? ST_DONE : ST_RD;
            ST_DONE: if (!mv_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        action_next = action_reg;
        kind_next   = kind_reg;
        len_next    = len_reg;
        p_next      = p_reg;
        end_next    = end_reg;
        run_next    = run_reg;
        q_next      = q_reg;
        first_next  = first_reg;
        stat_next   = stat_reg;
        tot_next    = tot_reg;
        kern_next   = kern_reg;
        clr_next    = clr_reg;
        mv_next     = mv_reg;
        ms_next     = ms_reg;
        mf_next     = mf_reg;
        mt_next     = mt_reg;
        mk_next     = mk_reg;
        mem_we      = 1'b0;
        mem_wd      = 1'b1;
        mem_wa      = p_reg[AW-1:0];
        s_ready     = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg[AW-1:0];
                clr_next = clr_reg + (AW+1)'(1);
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    action_next = s_action;
                    kind_next   = s_kernel_kind;
                    len_next    = s_len_x;
                    run_next    = '0;
                    first_next  = '0;
                    end_next    = s_start_x + s_len_x;
                    p_next      = (s_action == ACT_ALLOC) ? start_x : s_start_x;
                    stat_next   = STAT_OK;
                    if (s_len_x == '0) begin
                        stat_next = STAT_BAD;
                    end else if (s_action == ACT_ALLOC) begin
                        if (s_len_x > PC_X) stat_next = STAT_BAD;
                        else if (start_x >= PC_X) stat_next = STAT_NOSPACE;
                    end else if (s_start_x >= PC_X || s_len_x > PC_X - s_start_x) begin
                        stat_next = STAT_BAD;
                    end
                end
            end
            ST_RD: ;
            ST_CHK: begin
                if (!rd_data && (page_is_kern == kind_reg)) begin
                    run_next = run_inc;
                    if (run_inc == len_reg) begin
                        first_next = p_inc - len_reg;
                        q_next     = p_inc - len_reg;
                    end else begin
                        p_next = p_inc;
                    end
                end else begin
                    run_next = '0;
                    p_next   = p_inc;
                end
                if (!(!rd_data && (page_is_kern == kind_reg) && run_inc == len_reg)
                    && p_inc >= PC_X) stat_next = STAT_NOSPACE;
            end
            ST_MARK: begin
                mem_we = 1'b1;
                mem_wa = q_reg[AW-1:0];
                q_next = q_reg + XW'(1);
                if (q_reg == p_reg) begin
                    tot_next = (len_reg > XW'(tot_reg)) ? '0 : tot_reg - len_reg[15:0];
                    if (kind_reg)
                        kern_next = (len_reg > XW'(kern_reg)) ? '0
                                  : kern_reg - len_reg[15:0];
                end
            end
            ST_FCHK: begin
                if (rd_data) begin
                    mem_we = 1'b1;
                    mem_wd = 1'b0;
                    if (tot_reg != 16'hFFFF) tot_next = tot_reg + 16'd1;
                    if (page_is_kern && kern_reg != 16'hFFFF) kern_next = kern_reg + 16'd1;
                end
                p_next = p_inc;
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    ms_next = stat_reg;
                    mf_next = (stat_reg == STAT_OK && action_reg == ACT_ALLOC)
                            ? first_reg[14:0] : 15'd0;
                    mt_next = tot_reg;
                    mk_next = kern_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            mv_reg        <= 1'b0;
            tot_reg       <= '0;
            kern_reg      <= '0;
            start_cfg_reg <= START_PAGE_RST;
            limit_cfg_reg <= KERNEL_LIMIT_RST;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
            tot_reg   <= tot_next;
            kern_reg  <= kern_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_START: start_cfg_reg <= cfg_wdata[14:0];
                    REG_LIMIT: limit_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        kind_reg   <= kind_next;
        len_reg    <= len_next;
        p_reg      <= p_next;
        end_reg    <= end_next;
        run_reg    <= run_next;
        q_reg      <= q_next;
        first_reg  <= first_next;
        stat_reg   <= stat_next;
        ms_reg     <= ms_next;
        mf_reg     <= mf_next;
        mt_reg     <= mt_next;
        mk_reg     <= mk_next;
    end

    assign m_valid       = mv_reg;
    assign m_status      = ms_reg;
    assign m_first_page  = mf_reg;
    assign m_free_total  = mt_reg;
    assign m_free_kernel = mk_reg;

    `PFA_ASSERT(a_mark_full_run, aclk, aresetn, (state_reg == ST_MARK) |-> (run_reg == len_reg), "marking a short run")
    `PFA_ASSERT(a_free_in_range, aclk, aresetn, (state_reg == ST_FCHK) |-> (p_reg < end_reg), "free walk past run end")
    `PFA_ASSERT(a_no_accept_clear, aclk, aresetn, (state_reg == ST_CLEAR) |-> !s_ready, "accept during clearing")
endmodule
